FILE: hw/rtl/mppc_pkg.sv
// mppc_pkg: field widths, register indexes and outcode bits for the map point
// projection and clip unit
// no dependencies
package mppc_pkg;

	localparam int unsigned LAT_W      = 31;
	localparam int unsigned LON_W      = 32;
	localparam int unsigned GAIN_W     = 32;
	localparam int unsigned SIZE_W     = 13;
	localparam int unsigned PIX_W      = 16;
	localparam int unsigned CODE_W     = 4;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned COORD_FRAC_BITS_DEF = 8;
	localparam int unsigned MARGIN_FACTOR       = 4;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(240);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_LAT = 3'd0,
		CFG_CENTER_LON = 3'd1,
		CFG_X_GAIN     = 3'd2,
		CFG_Y_GAIN     = 3'd3,
		CFG_WIDTH      = 3'd4,
		CFG_HEIGHT     = 3'd5
	} cfg_reg_t;

	localparam logic [CODE_W-1:0] CODE_LEFT  = 4'h1;
	localparam logic [CODE_W-1:0] CODE_RIGHT = 4'h2;
	localparam logic [CODE_W-1:0] CODE_ABOVE = 4'h4;
	localparam logic [CODE_W-1:0] CODE_BELOW = 4'h8;

endpackage

FILE: hw/rtl/mppc_if.sv
// mppc_point_if and mppc_segment_if: valid/ready channels for incoming points
// and outgoing segments; depends on mppc_pkg
interface mppc_point_if import mppc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [LAT_W-1:0]  latitude;
	logic signed [LON_W-1:0]  longitude;
	logic                     first_of_line;

	modport source (output valid, latitude, longitude, first_of_line, input ready);
	modport sink (input valid, latitude, longitude, first_of_line, output ready);
endinterface

interface mppc_segment_if import mppc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     draw_segment;
	logic signed [PIX_W-1:0]  start_x;
	logic signed [PIX_W-1:0]  start_y;
	logic signed [PIX_W-1:0]  end_x;
	logic signed [PIX_W-1:0]  end_y;
	logic [CODE_W-1:0]        side_code;
	logic [COUNT_W-1:0]       point_total;

	modport source (output valid, draw_segment, start_x, start_y, end_x, end_y, side_code,
		point_total, input ready);
	modport sink (input valid, draw_segment, start_x, start_y, end_x, end_y, side_code,
		point_total, output ready);
endinterface

FILE: hw/rtl/map_point_project_clip_unit.sv
// map_point_project_clip_unit: projects map points to pixels, computes their
// outcodes, clamps them and decides on trivial reject of each segment
// depends on mppc_pkg, mppc_point_if and mppc_segment_if
//
// usage
//   points   : sink channel, one transaction per map point (latitude, longitude
//              in 1e-7 degree, first_of_line starts a new polyline)
//   segments : source channel, exactly one transaction per point, in order
//   cfg_*    : register writes (view centre, Q0.32 gains, canvas size); write
//              only while no point is in flight
// timing
//   a five-register pipeline: difference, 32x32 gain multiply, offset from the
//   canvas centre, clamp and outcode, then the segment register holding the
//   previous point. a result is registered through all five, and one point is
//   taken every cycle unless the pipeline stalls; the number of stages sets the latency
// reset
//   arst_n clears the pipeline, the previous point, the point count and the
//   registers (canvas size to 240 by 240)
// stall
//   while a result waits and segments.ready is low the whole pipeline holds
//   and points.ready falls in the same cycle
module map_point_project_clip_unit import mppc_pkg::*; #(
	parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	mppc_point_if.sink             points,
	mppc_segment_if.source         segments
);

	localparam int unsigned MAG_W  = LON_W;
	localparam int unsigned PROD_W = MAG_W + GAIN_W;
	localparam int unsigned SHIFT  = GAIN_W - COORD_FRAC_BITS;
	localparam int unsigned P_W    = PROD_W - SHIFT;
	localparam int unsigned XQ_W   = P_W + 2;
	localparam int unsigned PX_W   = XQ_W - COORD_FRAC_BITS;
	localparam int unsigned HALF_W = SIZE_W + COORD_FRAC_BITS;

	localparam logic signed [PX_W-1:0] MARGIN_PX = PX_W'(MARGIN_FACTOR);
	localparam logic signed [PX_W-1:0] SAT_HI    = PX_W'((2 ** (PIX_W - 1)) - 1);
	localparam logic signed [PX_W-1:0] SAT_LO    = -SAT_HI - PX_W'(1);
	localparam logic [XQ_W-1:0]        RND       = (XQ_W'(1) << COORD_FRAC_BITS) - XQ_W'(1);

	// configuration
	logic signed [LAT_W-1:0] cen_lat_q;
	logic signed [LON_W-1:0] cen_lon_q;
	logic [GAIN_W-1:0]       x_gain_q;
	logic [GAIN_W-1:0]       y_gain_q;
	logic [SIZE_W-1:0]       width_q;
	logic [SIZE_W-1:0]       height_q;

	// pipeline
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    first_s1, first_s2, first_s3, first_s4;
	logic [MAG_W-1:0]        mag_x_s1, mag_y_s1;
	logic                    neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2;
	logic [P_W-1:0]          px_s2, py_s2;
	logic signed [XQ_W-1:0]  xq_s3, yq_s3;
	logic [PIX_W-1:0]        ex_s4, ey_s4;
	logic [CODE_W-1:0]       code_s4;

	// previous point and result
	logic                    out_valid_q;
	logic                    have_last_q;
	logic [PIX_W-1:0]        last_x_q, last_y_q;
	logic [CODE_W-1:0]       last_code_q;
	logic [COUNT_W-1:0]      points_seen_q;
	logic                    draw_q;
	logic [PIX_W-1:0]        start_x_q, start_y_q;

	logic                    adv;
	logic signed [LON_W:0]   dx;
	logic [LON_W:0]          dx_abs;
	logic signed [LAT_W:0]   dy;
	logic [LAT_W:0]          dy_abs;
	logic [PROD_W-1:0]       prod_x, prod_y;
	logic [HALF_W-1:0]       half_w, half_h;
	logic signed [XQ_W-1:0]  half_wx, half_hx, px_x, py_x;
	logic [PIX_W-1:0]        ex, ey;
	logic [CODE_W-1:0]       code;
	logic                    prev;

	function automatic logic [PIX_W-1:0] clamp_px(logic signed [XQ_W-1:0] q,
		logic [SIZE_W-1:0] size);
		logic signed [PX_W-1:0] size_px, lo_px, hi_px, tr, v;
		logic signed [XQ_W-1:0] lo_q, hi_q, rnd, sh;
		size_px = PX_W'(size);
		lo_px   = -(size_px * MARGIN_PX);
		hi_px   = size_px + size_px * MARGIN_PX;
		lo_q    = XQ_W'(lo_px) <<< COORD_FRAC_BITS;
		hi_q    = XQ_W'(hi_px) <<< COORD_FRAC_BITS;
		rnd     = q + (q[XQ_W-1] ? signed'(RND) : signed'(XQ_W'(0)));
		sh      = rnd >>> COORD_FRAC_BITS;
		tr      = sh[PX_W-1:0];
		if (q < lo_q) begin
			v = lo_px;
		end else if (q > hi_q) begin
			v = hi_px;
		end else begin
			v = tr;
		end
		if (v > SAT_HI) begin
			v = SAT_HI;
		end else if (v < SAT_LO) begin
			v = SAT_LO;
		end
		return v[PIX_W-1:0];
	endfunction

	function automatic logic [1:0] side_bits(logic signed [XQ_W-1:0] q,
		logic [SIZE_W-1:0] size);
		logic signed [XQ_W-1:0] sq;
		sq = signed'(XQ_W'(size)) <<< COORD_FRAC_BITS;
		if (q < 0) begin
			return 2'b01;
		end else if (q > sq) begin
			return 2'b10;
		end
		return 2'b00;
	endfunction

	assign adv          = !out_valid_q || segments.ready;
	assign points.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_lat_q <= '0;
			cen_lon_q <= '0;
			x_gain_q  <= '0;
			y_gain_q  <= '0;
			width_q   <= SIZE_RESET;
			height_q  <= SIZE_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_CENTER_LAT: cen_lat_q <= cfg_data[LAT_W-1:0];
				CFG_CENTER_LON: cen_lon_q <= cfg_data[LON_W-1:0];
				CFG_X_GAIN:     x_gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_Y_GAIN:     y_gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_WIDTH:      width_q   <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT:     height_q  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// offset from the view centre, as sign and magnitude
	always_comb begin
		dx     = {points.longitude[LON_W-1], points.longitude} - {cen_lon_q[LON_W-1], cen_lon_q};
		dx_abs = dx[LON_W] ? -dx : dx;
		dy     = {points.latitude[LAT_W-1], points.latitude} - {cen_lat_q[LAT_W-1], cen_lat_q};
		dy_abs = dy[LAT_W] ? -dy : dy;
	end

	assign prod_x = PROD_W'(mag_x_s1) * PROD_W'(x_gain_q);
	assign prod_y = PROD_W'(mag_y_s1) * PROD_W'(y_gain_q);

	always_comb begin
		half_w  = (HALF_W'(width_q) << COORD_FRAC_BITS) >> 1;
		half_h  = (HALF_W'(height_q) << COORD_FRAC_BITS) >> 1;
		half_wx = XQ_W'(half_w);
		half_hx = XQ_W'(half_h);
		px_x    = XQ_W'(px_s2);
		py_x    = XQ_W'(py_s2);
	end

	always_comb begin
		ex   = clamp_px(xq_s3, width_q);
		ey   = clamp_px(yq_s3, height_q);
		code = '0;
		case (side_bits(xq_s3, width_q))
			2'b01:   code = code | CODE_LEFT;
			2'b10:   code = code | CODE_RIGHT;
			default: ;
		endcase
		case (side_bits(yq_s3, height_q))
			2'b01:   code = code | CODE_ABOVE;
			2'b10:   code = code | CODE_BELOW;
			default: ;
		endcase
	end

	assign prev = have_last_q && !first_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= points.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= points.first_of_line;
			mag_x_s1 <= dx_abs[MAG_W-1:0];
			neg_x_s1 <= dx[LON_W];
			mag_y_s1 <= MAG_W'(dy_abs);
			neg_y_s1 <= dy[LAT_W];

			first_s2 <= first_s1;
			px_s2    <= prod_x[PROD_W-1:SHIFT];
			py_s2    <= prod_y[PROD_W-1:SHIFT];
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;

			// screen y grows downwards
			first_s3 <= first_s2;
			xq_s3    <= neg_x_s2 ? half_wx - px_x : half_wx + px_x;
			yq_s3    <= neg_y_s2 ? half_hx + py_x : half_hx - py_x;

			first_s4 <= first_s3;
			ex_s4    <= ex;
			ey_s4    <= ey;
			code_s4  <= code;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			draw_q    <= prev && ((last_code_q & code_s4) == '0);
			start_x_q <= prev ? last_x_q : '0;
			start_y_q <= prev ? last_y_q : '0;
		end
	end

	// the previous point doubles as the end of the current segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_last_q   <= 1'b0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			last_code_q   <= '0;
			points_seen_q <= '0;
		end else if (adv && v_s4) begin
			have_last_q   <= 1'b1;
			last_x_q      <= ex_s4;
			last_y_q      <= ey_s4;
			last_code_q   <= code_s4;
			points_seen_q <= points_seen_q + COUNT_W'(1);
		end
	end

	assign segments.valid        = out_valid_q;
	assign segments.draw_segment = draw_q;
	assign segments.start_x      = start_x_q;
	assign segments.start_y      = start_y_q;
	assign segments.end_x        = last_x_q;
	assign segments.end_y        = last_y_q;
	assign segments.side_code    = last_code_q;
	assign segments.point_total  = points_seen_q;

endmodule

FILE: hw/rtl/mppc_checker.sv
// mppc_checker: port-level checks on the segment channel of the projection
// and clip unit; depends on mppc_pkg, bound to map_point_project_clip_unit
module mppc_checker import mppc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               seg_valid,
	input logic               seg_ready,
	input logic               draw_segment,
	input logic [PIX_W-1:0]   start_x,
	input logic [PIX_W-1:0]   start_y,
	input logic [PIX_W-1:0]   end_x,
	input logic [PIX_W-1:0]   end_y,
	input logic [CODE_W-1:0]  side_code,
	input logic [COUNT_W-1:0] point_total
);

	logic                seen_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [PIX_W-1:0]    prev_x_q, prev_y_q;
	logic [CODE_W-1:0]   prev_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			out_count_q <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_code_q <= '0;
		end else if (seg_valid && seg_ready) begin
			seen_q      <= 1'b1;
			out_count_q <= out_count_q + COUNT_W'(1);
			prev_x_q    <= end_x;
			prev_y_q    <= end_y;
			prev_code_q <= side_code;
		end
	end

	// count follows the delivered transactions
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> point_total == out_count_q + COUNT_W'(1))
		else $error("point_total out of step with delivered transactions");

	// a drawn segment starts where the last one ended and is not rejected
	a_draw: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && draw_segment |-> seen_q && start_x == prev_x_q && start_y == prev_y_q
			&& (side_code & prev_code_q) == '0)
		else $error("drawn segment does not chain or shares an outcode side");

	a_side: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> !(side_code[0] && side_code[1]) && !(side_code[2] && side_code[3]))
		else $error("outcode marks opposite sides");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(draw_segment) && $stable(start_x)
			&& $stable(start_y) && $stable(end_x) && $stable(end_y) && $stable(side_code)
			&& $stable(point_total))
		else $error("stalled segment transaction changed");

endmodule

bind map_point_project_clip_unit mppc_checker u_mppc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.seg_valid    (segments.valid),
	.seg_ready    (segments.ready),
	.draw_segment (segments.draw_segment),
	.start_x      (segments.start_x),
	.start_y      (segments.start_y),
	.end_x        (segments.end_x),
	.end_y        (segments.end_y),
	.side_code    (segments.side_code),
	.point_total  (segments.point_total)
);
